FILE: sv/cc20_pkg.sv
// shared types, constants and the quarter-round half function of the chacha20 cipher
package cc20_pkg;

   typedef logic [31:0] word_type;

   localparam word_type SIGMA_0 = 32'h6170_7865;
   localparam word_type SIGMA_1 = 32'h3320_646e;
   localparam word_type SIGMA_2 = 32'h7962_2d32;
   localparam word_type SIGMA_3 = 32'h6b20_6574;

   localparam int BLOCK_BYTES = 64;
   localparam int POS_BITS    = $clog2(BLOCK_BYTES);
   localparam int HALF_STEPS  = 40;
   localparam int STEP_BITS   = $clog2(HALF_STEPS);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] REG_KEY_01   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KEY_23   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KEY_45   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KEY_67   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NONCE_01 = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NONCE_2  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CTR_INIT = 3'd6;

   typedef struct packed {
      logic capture;
      logic load;
      logic step;
      logic diag;
      logic second;
      logic final_add;
      logic emit;
      logic emit_direct;
   } dp_cmd_type;

   typedef struct packed {
      logic ks_valid;
   } dp_status_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } qr_type;

   // one half of the arx quarter round, second half uses rotations 8 and 7
   function automatic qr_type qr_half(input word_type a, input word_type b,
                                      input word_type c, input word_type d,
                                      input logic second);
      qr_type   r;
      word_type a1;
      word_type c1;
      word_type dx;
      word_type bx;
      a1 = a + b;
      dx = d ^ a1;
      r.a = a1;
      r.d = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
      c1 = c + r.d;
      bx = b ^ c1;
      r.c = c1;
      r.b = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
      return r;
   endfunction

endpackage

FILE: sv/chacha20_stream_cipher.sv
// chacha20 byte stream cipher: a held keystream byte gives a result in the cycle after
// transfer; a byte that needs a new block waits through load, 40 half double-round steps
// of four parallel quarter-round halves, final add, then the result; one byte per cycle
// while a block is held and the result register is not stalled; reset is synchronous and
// clears the configuration, the block counter and the held-block flag, after it the first
// byte generates a new block
module chacha20_stream_cipher (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_restart,
   input  logic                                req_end_of_message,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_result_byte,
   output logic                                rsp_result_last,
   input  logic                                csr_wr_en,
   input  logic [cc20_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cc20_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   cc20_pkg::dp_cmd_type    cmd;
   cc20_pkg::dp_status_type status;

   cc20_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   cc20_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_data_byte      (req_data_byte),
      .req_restart        (req_restart),
      .req_end_of_message (req_end_of_message),
      .rsp_result_byte    (rsp_result_byte),
      .rsp_result_last    (rsp_result_last)
   );

endmodule

FILE: sv/cc20_control.sv
// sequencer for block generation, round counting and the result register handshake
module cc20_control (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_restart,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  cc20_pkg::dp_status_type   status,
   output cc20_pkg::dp_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_FINAL = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   localparam logic [cc20_pkg::STEP_BITS-1:0] LAST_STEP =
      cc20_pkg::STEP_BITS'(cc20_pkg::HALF_STEPS - 1);

   logic [2:0]                     state_ff, state_in;
   logic [cc20_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               if (status.ks_valid && !req_restart) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_direct = 1'b1;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            step_in  = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.step   = 1'b1;
            cmd.diag   = step_ff[1];
            cmd.second = step_ff[0];
            step_in    = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.final_add = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/cc20_datapath.sv
// key and nonce registers, 16-word working state, block counter and byte xor
module cc20_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cc20_pkg::dp_cmd_type                  cmd,
   output cc20_pkg::dp_status_type               status,
   input  logic                                  csr_wr_en,
   input  logic [cc20_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [cc20_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_restart,
   input  logic                                  req_end_of_message,
   output logic [7:0]                            rsp_result_byte,
   output logic                                  rsp_result_last
);

   logic [63:0]                   key01_ff, key23_ff, key45_ff, key67_ff, nonce01_ff;
   logic [31:0]                   nonce2_ff, ctr_init_ff;
   cc20_pkg::word_type            counter_ff, counter_in;
   logic [cc20_pkg::POS_BITS-1:0] pos_ff, pos_in;
   logic                          ks_valid_ff, ks_valid_in;
   cc20_pkg::word_type            work_ff [16];
   cc20_pkg::word_type            work_in [16];
   cc20_pkg::word_type            init_w  [16];
   cc20_pkg::word_type            step_w  [16];
   cc20_pkg::qr_type              qr_w    [4];
   logic [7:0]                    data_ff;
   logic                          last_ff;
   logic [7:0]                    rsp_byte_ff;
   logic                          rsp_last_ff;
   logic [7:0]                    ks_byte;
   logic [7:0]                    src_byte;
   logic                          src_last;
   cc20_pkg::word_type            ks_word;

   assign init_w[0]  = cc20_pkg::SIGMA_0;
   assign init_w[1]  = cc20_pkg::SIGMA_1;
   assign init_w[2]  = cc20_pkg::SIGMA_2;
   assign init_w[3]  = cc20_pkg::SIGMA_3;
   assign init_w[4]  = key01_ff[31:0];
   assign init_w[5]  = key01_ff[63:32];
   assign init_w[6]  = key23_ff[31:0];
   assign init_w[7]  = key23_ff[63:32];
   assign init_w[8]  = key45_ff[31:0];
   assign init_w[9]  = key45_ff[63:32];
   assign init_w[10] = key67_ff[31:0];
   assign init_w[11] = key67_ff[63:32];
   assign init_w[12] = counter_ff;
   assign init_w[13] = nonce01_ff[31:0];
   assign init_w[14] = nonce01_ff[63:32];
   assign init_w[15] = nonce2_ff;

   // four quarter-round halves in parallel, column or diagonal selection
   for (genvar q = 0; q < 4; q++) begin : g_qr
      localparam int DB = 4 + ((q + 1) % 4);
      localparam int DC = 8 + ((q + 2) % 4);
      localparam int DD = 12 + ((q + 3) % 4);
      cc20_pkg::word_type b_sel, c_sel, d_sel;
      assign b_sel = cmd.diag ? work_ff[DB] : work_ff[4 + q];
      assign c_sel = cmd.diag ? work_ff[DC] : work_ff[8 + q];
      assign d_sel = cmd.diag ? work_ff[DD] : work_ff[12 + q];
      assign qr_w[q] = cc20_pkg::qr_half(work_ff[q], b_sel, c_sel, d_sel, cmd.second);
   end

   for (genvar j = 0; j < 4; j++) begin : g_route
      assign step_w[j]      = qr_w[j].a;
      assign step_w[4 + j]  = cmd.diag ? qr_w[(j + 3) % 4].b : qr_w[j].b;
      assign step_w[8 + j]  = cmd.diag ? qr_w[(j + 2) % 4].c : qr_w[j].c;
      assign step_w[12 + j] = cmd.diag ? qr_w[(j + 1) % 4].d : qr_w[j].d;
   end

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         if (cmd.load) begin
            work_in[i] = init_w[i];
         end else if (cmd.step) begin
            work_in[i] = step_w[i];
         end else if (cmd.final_add) begin
            work_in[i] = work_ff[i] + init_w[i];
         end else begin
            work_in[i] = work_ff[i];
         end
      end
   end

   assign ks_word  = work_ff[pos_ff[cc20_pkg::POS_BITS-1:2]];
   assign ks_byte  = ks_word[{pos_ff[1:0], 3'b000} +: 8];
   assign src_byte = cmd.emit_direct ? req_data_byte : data_ff;
   assign src_last = cmd.emit_direct ? req_end_of_message : last_ff;

   always_comb begin
      counter_in  = counter_ff;
      pos_in      = pos_ff;
      ks_valid_in = ks_valid_ff;
      if (csr_wr_en) begin
         case (csr_index)
            cc20_pkg::REG_KEY_01, cc20_pkg::REG_KEY_23, cc20_pkg::REG_KEY_45,
            cc20_pkg::REG_KEY_67, cc20_pkg::REG_NONCE_01, cc20_pkg::REG_NONCE_2: begin
               pos_in      = '0;
               ks_valid_in = 1'b0;
            end
            cc20_pkg::REG_CTR_INIT: begin
               pos_in      = '0;
               ks_valid_in = 1'b0;
               counter_in  = csr_data[31:0];
            end
            default: begin
               pos_in = pos_ff;
            end
         endcase
      end
      if (cmd.capture && req_restart) begin
         counter_in  = ctr_init_ff;
         pos_in      = '0;
         ks_valid_in = 1'b0;
      end
      if (cmd.final_add) begin
         counter_in  = counter_ff + 32'd1;
         pos_in      = '0;
         ks_valid_in = 1'b1;
      end
      if (cmd.emit) begin
         pos_in = pos_ff + 1'b1;
         if (&pos_ff) begin
            ks_valid_in = 1'b0;
         end
         if (src_last) begin
            pos_in      = '0;
            ks_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key01_ff    <= '0;
         key23_ff    <= '0;
         key45_ff    <= '0;
         key67_ff    <= '0;
         nonce01_ff  <= '0;
         nonce2_ff   <= '0;
         ctr_init_ff <= '0;
         counter_ff  <= '0;
         pos_ff      <= '0;
         ks_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               cc20_pkg::REG_KEY_01:   key01_ff    <= csr_data;
               cc20_pkg::REG_KEY_23:   key23_ff    <= csr_data;
               cc20_pkg::REG_KEY_45:   key45_ff    <= csr_data;
               cc20_pkg::REG_KEY_67:   key67_ff    <= csr_data;
               cc20_pkg::REG_NONCE_01: nonce01_ff  <= csr_data;
               cc20_pkg::REG_NONCE_2:  nonce2_ff   <= csr_data[31:0];
               cc20_pkg::REG_CTR_INIT: ctr_init_ff <= csr_data[31:0];
               default: begin
                  ctr_init_ff <= ctr_init_ff;
               end
            endcase
         end
         counter_ff  <= counter_in;
         pos_ff      <= pos_in;
         ks_valid_ff <= ks_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) begin
         work_ff[i] <= work_in[i];
      end
      if (cmd.capture) begin
         data_ff <= req_data_byte;
         last_ff <= req_end_of_message;
      end
      if (cmd.emit) begin
         rsp_byte_ff <= src_byte ^ ks_byte;
         rsp_last_ff <= src_last;
      end
   end

   assign status.ks_valid = ks_valid_ff;
   assign rsp_result_byte = rsp_byte_ff;
   assign rsp_result_last = rsp_last_ff;

endmodule

FILE: sv/cc20_checker.sv
// port-level checks of the cipher's transfer behavior, bound to the top level
module cc20_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [7:0]                          rsp_result_byte,
   input logic                                rsp_result_last
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_byte)
                                 && $stable(rsp_result_last))
      else $error("stalled result changed");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result register is blocked");

   a_result_or_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid || !req_ready)
      else $error("transfer neither answered nor followed by a stall");

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (.*);
